@@ rtl/core/psa_pkg.sv @@
package psa_pkg;

   localparam int OP_W     = 3;
   localparam int SLOT_W   = 6;
   localparam int HANDLE_W = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;
   localparam int SRC_W    = 2;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [HANDLE_W-1:0] handle_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [SRC_W-1:0]    src_type;

   // operation codes
   localparam op_type OP_ALLOC   = 3'd0;
   localparam op_type OP_RELEASE = 3'd1;
   localparam op_type OP_LOOKUP  = 3'd2;
   localparam op_type OP_FIRST   = 3'd3;
   localparam op_type OP_NEXT    = 3'd4;
   localparam op_type OP_PREV    = 3'd5;

   // result status codes
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_EMPTY = 2'd2;

   // where the returned handle comes from
   localparam src_type SRC_ZERO = 2'd0;
   localparam src_type SRC_MEM  = 2'd1;
   localparam src_type SRC_REQ  = 2'd2;

   typedef struct packed {
      op_type     operation;
      slot_type   slot;
      handle_type handle;
   } req_type;

   typedef struct packed {
      status_type status;
      slot_type   slot;
      src_type    src;
      count_type  count;
   } outcome_type;

endpackage

@@ rtl/core/psa_handle_mem.sv @@
module psa_handle_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single port, read returns the old contents
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            ram_ff[addr] <= wr_data;
         end
         rd_data_ff <= ram_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/psa_table.sv @@
module psa_table #(
   parameter int SLOTS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     exec_en,
   input  psa_pkg::req_type         req,
   output psa_pkg::outcome_type     res,
   output logic                     mem_we,
   output logic [$clog2(SLOTS)-1:0] mem_addr
);

   localparam int SW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [SLOTS-1:0] UnitVec = {{(SLOTS-1){1'b0}}, 1'b1};
   localparam logic [SLOTS-1:0] TopVec  = {1'b1, {(SLOTS-1){1'b0}}};
   localparam logic [SW-1:0]    LastIdx = SW'(SLOTS - 1);

   logic [SLOTS-1:0] occ_ff, occ_in;
   logic [SW-1:0]    alloc_cur_ff, alloc_cur_in;
   logic [SW-1:0]    browse_cur_ff, browse_cur_in;
   logic             browse_set_ff, browse_set_in;
   logic [CW-1:0]    count_ff, count_in;

   logic [SLOTS-1:0] below_cur;
   logic [SLOTS-1:0] at_cur;
   logic [SLOTS-1:0] free_vec;
   logic [SLOTS-1:0] free_ahead;
   logic [SW-1:0]    tgt;
   logic [SW-1:0]    pos;
   logic             pos_ok;
   logic [SW-1:0]    req_idx;
   logic             req_hit;
   logic             full;

   // lowest set bit: isolate with one add, then encode the one-hot word
   function automatic logic [SW-1:0] first_set(input logic [SLOTS-1:0] v);
      logic [SLOTS-1:0] iso;
      logic [SW-1:0]    idx;
      iso = v & (~v + UnitVec);
      idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (iso[i]) begin
            idx = idx | SW'(i);
         end
      end
      return idx;
   endfunction

   function automatic logic [SW-1:0] last_set(input logic [SLOTS-1:0] v);
      logic [SLOTS-1:0] rev;
      for (int i = 0; i < SLOTS; i++) begin
         rev[i] = v[SLOTS-1-i];
      end
      return LastIdx - first_set(rev);
   endfunction

   assign full       = (count_ff == CW'(SLOTS));
   assign free_vec   = ~occ_ff;
   assign free_ahead = free_vec & ~((UnitVec << alloc_cur_ff) - UnitVec);
   assign tgt        = (|free_ahead) ? first_set(free_ahead) : first_set(free_vec);

   assign at_cur    = UnitVec << browse_cur_ff;
   assign below_cur = at_cur - UnitVec;

   assign req_idx = SW'(req.slot);
   assign req_hit = (int'(req.slot) < SLOTS) && occ_ff[req_idx];

   // browse target; pos_ok low only for previous with the cursor unset
   always_comb begin
      pos    = '0;
      pos_ok = 1'b1;
      case (req.operation)
         psa_pkg::OP_NEXT: begin
            if (!browse_set_ff) begin
               pos = first_set(occ_ff | TopVec);
            end else if (browse_cur_ff != LastIdx) begin
               pos = first_set((occ_ff & ~(below_cur | at_cur)) | TopVec);
            end else begin
               pos = browse_cur_ff;
            end
         end
         psa_pkg::OP_PREV: begin
            if (!browse_set_ff) begin
               pos_ok = 1'b0;
            end else if (browse_cur_ff != '0) begin
               pos = last_set((occ_ff & below_cur) | UnitVec);
            end else begin
               pos = '0;
            end
         end
         default: begin
            pos = '0;
         end
      endcase
   end

   always_comb begin
      occ_in        = occ_ff;
      alloc_cur_in  = alloc_cur_ff;
      browse_cur_in = browse_cur_ff;
      browse_set_in = browse_set_ff;
      count_in      = count_ff;
      mem_we        = 1'b0;
      mem_addr      = '0;
      res.status    = psa_pkg::ST_EMPTY;
      res.slot      = '0;
      res.src       = psa_pkg::SRC_ZERO;
      if (exec_en) begin
         case (req.operation)
            psa_pkg::OP_ALLOC: begin
               if (full) begin
                  res.status = psa_pkg::ST_FULL;
               end else begin
                  occ_in[tgt]  = 1'b1;
                  count_in     = count_ff + CW'(1);
                  alloc_cur_in = tgt;
                  mem_we       = 1'b1;
                  mem_addr     = tgt;
                  res.status   = psa_pkg::ST_OK;
                  res.slot     = psa_pkg::slot_type'(tgt);
                  res.src      = psa_pkg::SRC_REQ;
               end
            end
            psa_pkg::OP_RELEASE: begin
               res.slot = req.slot;
               if (req_hit) begin
                  occ_in[req_idx] = 1'b0;
                  count_in        = count_ff - CW'(1);
                  res.status      = psa_pkg::ST_OK;
               end
            end
            psa_pkg::OP_LOOKUP: begin
               res.slot = req.slot;
               mem_addr = req_idx;
               if (req_hit) begin
                  res.status = psa_pkg::ST_OK;
                  res.src    = psa_pkg::SRC_MEM;
               end
            end
            psa_pkg::OP_FIRST, psa_pkg::OP_NEXT, psa_pkg::OP_PREV: begin
               if (pos_ok) begin
                  browse_cur_in = pos;
                  browse_set_in = 1'b1;
                  mem_addr      = pos;
                  res.slot      = psa_pkg::slot_type'(pos);
                  if (occ_ff[pos]) begin
                     res.status = psa_pkg::ST_OK;
                     res.src    = psa_pkg::SRC_MEM;
                  end
               end
            end
            default: begin
               res.status = psa_pkg::ST_EMPTY;
            end
         endcase
      end
      res.count = psa_pkg::count_type'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff        <= '0;
         alloc_cur_ff  <= '0;
         browse_cur_ff <= '0;
         browse_set_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         occ_ff        <= occ_in;
         alloc_cur_ff  <= alloc_cur_in;
         browse_cur_ff <= browse_cur_in;
         browse_set_ff <= browse_set_in;
         count_ff      <= count_in;
      end
   end

endmodule

@@ rtl/core/process_slot_allocator_unit.sv @@
// process slot allocator: a table of SLOTS process-id slots, each holding a handle and an
// occupied mark. allocate (operation 0) takes the first free slot at or after a wrapping
// cursor that rests on the slot last allocated, stores the handle and returns the slot, or
// status full when every slot is taken; release (1) frees a slot, lookup (2) returns a
// slot's handle, and browse first/next/previous (3/4/5) walk a browse cursor that skips
// empty slots but stops at the table ends. status 2 marks an empty slot, an unset cursor,
// a slot beyond the table or an unknown operation; handle_out is zero whenever the slot is
// empty. every request beat gives exactly one response beat carrying the occupied count
// after the operation. one request is handled at a time: in its exec cycle the occupied
// bitmap is scanned and updated (a rotating find-first over the whole bitmap) while the
// handle ram is written or read, and in its finish cycle the ram read data lands in the
// response register. a new request is taken on the edge that loads the response, so
// requests never overlap in the block; a stalled response register holds the next
// request off. no clearing pass after reset: the occupied bitmap is cleared at once and
// the handle ram data is only used for occupied slots
module process_slot_allocator_unit #(
   parameter int SLOTS       = 64,
   parameter int HANDLE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // slot [5:0], handle [37:6], zero fill [39:38]
   input  logic [2:0]  req_tuser,   // operation [2:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // slot_out [5:0], handle_out [37:6],
                                    // occupied_count [44:38], zero fill [47:45]
   output logic [1:0]  rsp_tuser    // status [1:0]
);

   localparam int SW = $clog2(SLOTS);

   // sequencing: busy marks a request held in req_ff, phase picks scan or finish cycle
   logic busy_ff, busy_in;
   logic phase_ff, phase_in;
   logic exec_en;
   logic can_load;
   logic finish;
   logic req_beat_ok;

   psa_pkg::req_type     req_beat;
   psa_pkg::req_type     req_ff;
   psa_pkg::outcome_type res;
   psa_pkg::outcome_type res_ff;

   logic                   mem_we;
   logic [SW-1:0]          mem_addr;
   logic [HANDLE_BITS-1:0] mem_wr_data;
   logic [HANDLE_BITS-1:0] mem_rd_data;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   psa_pkg::status_type    rsp_status_ff;
   psa_pkg::slot_type      rsp_slot_ff;
   psa_pkg::handle_type    rsp_handle_ff, rsp_handle_in;
   psa_pkg::count_type     rsp_count_ff;

   assign req_beat.operation = req_tuser;
   assign req_beat.slot      = req_tdata[5:0];
   assign req_beat.handle    = req_tdata[37:6];

   assign exec_en     = busy_ff && !phase_ff;
   assign can_load    = !rsp_valid_ff || rsp_tready;
   assign finish      = busy_ff && phase_ff && can_load;
   // the next request enters on the same edge that the current one leaves
   assign req_tready  = !busy_ff || finish;
   assign req_beat_ok = req_tvalid && req_tready;

   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      if (req_beat_ok) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
      end else if (finish) begin
         busy_in = 1'b0;
      end else if (exec_en) begin
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat_ok) begin
         req_ff <= req_beat;
      end
      if (exec_en) begin
         res_ff <= res;
      end
   end

   // bitmap, cursors and count; scan and update in the exec cycle
   psa_table #(
      .SLOTS (SLOTS)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .exec_en  (exec_en),
      .req      (req_ff),
      .res      (res),
      .mem_we   (mem_we),
      .mem_addr (mem_addr)
   );

   // handle is cut to HANDLE_BITS on the way in
   assign mem_wr_data = HANDLE_BITS'(req_ff.handle);

   // the only write is the allocate in the exec cycle; the read for the same request
   // happens in that cycle too and the next request's read waits for its own exec cycle, so
   // accesses to one entry never overlap
   psa_handle_mem #(
      .DEPTH (SLOTS),
      .WIDTH (HANDLE_BITS)
   ) u_handle_mem (
      .clock   (clock),
      .en      (exec_en),
      .we      (mem_we),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      case (res_ff.src)
         psa_pkg::SRC_MEM: rsp_handle_in = psa_pkg::handle_type'(mem_rd_data);
         psa_pkg::SRC_REQ: rsp_handle_in = psa_pkg::handle_type'(mem_wr_data);
         default:          rsp_handle_in = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_status_ff <= res_ff.status;
         rsp_slot_ff   <= res_ff.slot;
         rsp_handle_ff <= rsp_handle_in;
         rsp_count_ff  <= res_ff.count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_handle_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

@@ tb/tb_top.sv @@
module tb_top;

   localparam int TABLE_SLOTS = 64;

   // operation codes the block treats as unknown
   localparam psa_pkg::op_type OP_SPARE_LO = 3'd6;
   localparam psa_pkg::op_type OP_SPARE_HI = 3'd7;

   // random traffic mixes
   localparam int MIX_FILL  = 0;
   localparam int MIX_BLEND = 1;
   localparam int MIX_DRAIN = 2;

   // run limit, far above the slowest correct run
   localparam int RUN_LIMIT = 2000000;

   // one response beat, field by field
   typedef struct {
      psa_pkg::status_type status;
      psa_pkg::slot_type   slot;
      psa_pkg::handle_type handle;
      psa_pkg::count_type  count;
   } slot_reply;

   // shadow of the slot table: predicts each reply and checks the ones that come back
   class slot_table_tracker;
      bit                  occ [TABLE_SLOTS];
      psa_pkg::handle_type handles [TABLE_SLOTS];
      int                  alloc_cur;
      int                  browse_cur;
      bit                  browse_on;
      int                  used;
      slot_reply           awaited_replies [$];
      int                  errors;
      int                  checked;

      function new();
         foreach (occ[i]) occ[i] = 1'b0;
         alloc_cur  = 0;
         browse_cur = 0;
         browse_on  = 1'b0;
         used       = 0;
         errors     = 0;
         checked    = 0;
      endfunction

      // handle of an occupied slot, or empty
      function slot_reply slot_report(int s);
         slot_reply r;
         r.slot = psa_pkg::slot_type'(s);
         if (occ[s]) begin
            r.status = psa_pkg::ST_OK;
            r.handle = handles[s];
         end else begin
            r.status = psa_pkg::ST_EMPTY;
            r.handle = '0;
         end
         return r;
      endfunction

      function void note_request(psa_pkg::op_type op, psa_pkg::slot_type s,
                                 psa_pkg::handle_type h);
         slot_reply r;
         int        pos;
         r.status = psa_pkg::ST_EMPTY;
         r.slot   = '0;
         r.handle = '0;
         pos      = browse_on ? browse_cur : -1;
         case (op)
            psa_pkg::OP_ALLOC: begin
               if (used >= TABLE_SLOTS) begin
                  r.status = psa_pkg::ST_FULL;
               end else begin
                  // cursor rests on the slot last allocated, so scan from there
                  for (int i = 0; i < TABLE_SLOTS && occ[alloc_cur]; i++)
                     alloc_cur = (alloc_cur + 1) % TABLE_SLOTS;
                  occ[alloc_cur]     = 1'b1;
                  handles[alloc_cur] = h;
                  used++;
                  r.status = psa_pkg::ST_OK;
                  r.slot   = psa_pkg::slot_type'(alloc_cur);
                  r.handle = h;
               end
            end
            psa_pkg::OP_RELEASE: begin
               r.slot = s;
               if (occ[s]) begin
                  occ[s] = 1'b0;
                  used--;
                  r.status = psa_pkg::ST_OK;
               end
            end
            psa_pkg::OP_LOOKUP: r = slot_report(s);
            psa_pkg::OP_FIRST, psa_pkg::OP_NEXT, psa_pkg::OP_PREV: begin
               if (op == psa_pkg::OP_FIRST) begin
                  pos = 0;
               end else if (op == psa_pkg::OP_NEXT) begin
                  // walk up over empty slots, stop on the last one
                  if (pos < TABLE_SLOTS - 1) begin
                     do pos++; while (pos < TABLE_SLOTS - 1 && !occ[pos]);
                  end
               end else begin
                  // walk down over empty slots, stop on slot zero
                  if (pos > 0) begin
                     do pos--; while (pos > 0 && !occ[pos]);
                  end
               end
               // previous with the cursor unset leaves it unset
               if (pos >= 0) begin
                  browse_cur = pos;
                  browse_on  = 1'b1;
                  r = slot_report(pos);
               end
            end
            default: ;
         endcase
         r.count = psa_pkg::count_type'(used);
         awaited_replies.push_back(r);
      endfunction

      function void check_response(psa_pkg::status_type status, psa_pkg::slot_type slot,
                                   psa_pkg::handle_type handle, psa_pkg::count_type count);
         slot_reply e;
         if (awaited_replies.size() == 0) begin
            $error("response beat with no request waiting");
            errors++;
            return;
         end
         e = awaited_replies.pop_front();
         checked++;
         if (status !== e.status) begin
            $error("status expected %0d got %0d", e.status, status);
            errors++;
         end
         if (slot !== e.slot) begin
            $error("slot_out expected %0d got %0d", e.slot, slot);
            errors++;
         end
         if (handle !== e.handle) begin
            $error("handle_out expected %h got %h", e.handle, handle);
            errors++;
         end
         if (count !== e.count) begin
            $error("occupied_count expected %0d got %0d", e.count, count);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // slot [5:0], handle [37:6], zero fill [39:38]
   logic [2:0]  req_tuser;   // operation [2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // slot_out [5:0], handle_out [37:6], occupied_count [44:38]
   logic [1:0]  rsp_tuser;   // status [1:0]

   slot_table_tracker tracker = new();

   // beats left in the current sender burst
   int burst_left = 0;

   process_slot_allocator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // both channels watched at the edge: values read here are the ones the block saw
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         tracker.note_request(req_tuser, req_tdata[5:0], req_tdata[37:6]);
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_response(rsp_tuser, rsp_tdata[5:0], rsp_tdata[37:6], rsp_tdata[44:38]);
   end

   // offer one request beat and hold it until taken; a gap may open a new burst first
   task automatic issue(psa_pkg::op_type op, psa_pkg::slot_type s, psa_pkg::handle_type h);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, h, s};
      do @(posedge clock); while (!req_tready);
   endtask

   // mostly an occupied slot so releases and lookups hit, sometimes any slot
   function automatic psa_pkg::slot_type pick_slot();
      int start;
      start = $urandom_range(0, TABLE_SLOTS - 1);
      if ($urandom_range(0, 3) != 0)
         for (int i = 0; i < TABLE_SLOTS; i++)
            if (tracker.occ[(start + i) % TABLE_SLOTS])
               return psa_pkg::slot_type'((start + i) % TABLE_SLOTS);
      return psa_pkg::slot_type'(start);
   endfunction

   // handles lean on the extremes now and then, zero included
   function automatic psa_pkg::handle_type pick_handle();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return '1;
         2:       return psa_pkg::handle_type'(1);
         default: return psa_pkg::handle_type'($urandom);
      endcase
   endfunction

   task automatic random_item(int mix, output psa_pkg::op_type op,
                              output psa_pkg::slot_type s, output psa_pkg::handle_type h);
      int roll;
      int alloc_pct;
      int release_pct;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:  begin alloc_pct = 72; release_pct = 10; end
         MIX_BLEND: begin alloc_pct = 35; release_pct = 30; end
         MIX_DRAIN: begin alloc_pct = 15; release_pct = 60; end
         default:   begin alloc_pct = 35; release_pct = 30; end
      endcase
      s = pick_slot();
      h = pick_handle();
      if (roll < alloc_pct) begin
         op = psa_pkg::OP_ALLOC;
         // slot field is ignored on allocate, so fill it with noise
         s  = psa_pkg::slot_type'($urandom);
      end else if (roll < alloc_pct + release_pct) begin
         op = psa_pkg::OP_RELEASE;
      end else if (roll < 98) begin
         case ($urandom_range(0, 4))
            0:       op = psa_pkg::OP_LOOKUP;
            1:       op = psa_pkg::OP_FIRST;
            2, 3:    op = psa_pkg::OP_NEXT;
            default: op = psa_pkg::OP_PREV;
         endcase
      end else begin
         op = ($urandom_range(0, 1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
      end
   endtask

   // sender: reset, directed beats, random phases, drain, verdict
   initial begin : req_side
      psa_pkg::op_type     op;
      psa_pkg::slot_type   s;
      psa_pkg::handle_type h;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, cursor unset
      issue(psa_pkg::OP_LOOKUP,  6'd0,  32'h0);
      issue(psa_pkg::OP_PREV,    6'd0,  32'h0);        // unset cursor stays unset
      issue(psa_pkg::OP_NEXT,    6'd0,  32'h0);        // scans to the last slot
      issue(psa_pkg::OP_PREV,    6'd63, 32'h0);        // back to slot zero, empty
      issue(psa_pkg::OP_FIRST,   6'd0,  32'h0);        // empty slot zero
      // allocations, zero handle included
      issue(psa_pkg::OP_ALLOC,   6'd63, 32'hFFFF_FFFF);
      issue(psa_pkg::OP_ALLOC,   6'd0,  32'h0);
      issue(psa_pkg::OP_ALLOC,   6'd21, 32'h1);
      issue(psa_pkg::OP_LOOKUP,  6'd1,  32'hFFFF_FFFF); // slot holding a zero handle
      issue(psa_pkg::OP_LOOKUP,  6'd0,  32'h0);
      issue(psa_pkg::OP_RELEASE, 6'd1,  32'h0);
      issue(psa_pkg::OP_RELEASE, 6'd1,  32'h0);        // already empty
      issue(psa_pkg::OP_LOOKUP,  6'd63, 32'h0);
      issue(psa_pkg::OP_RELEASE, 6'd63, 32'hFFFF_FFFF);
      issue(OP_SPARE_LO, 6'd63, 32'hFFFF_FFFF);
      issue(OP_SPARE_HI, 6'd42, 32'h1234_5678);
      // browse walk across gaps and against both ends
      issue(psa_pkg::OP_FIRST,   6'd0,  32'h0);
      issue(psa_pkg::OP_NEXT,    6'd0,  32'h0);
      issue(psa_pkg::OP_NEXT,    6'd0,  32'h0);
      issue(psa_pkg::OP_NEXT,    6'd0,  32'h0);        // pinned on the last slot
      issue(psa_pkg::OP_PREV,    6'd0,  32'h0);
      issue(psa_pkg::OP_PREV,    6'd0,  32'h0);
      issue(psa_pkg::OP_PREV,    6'd0,  32'h0);        // pinned on slot zero
      issue(psa_pkg::OP_ALLOC,   6'd0,  32'hAAAA_AAAA);
      issue(psa_pkg::OP_ALLOC,   6'd0,  32'h5555_5555);

      // fill, blend and drain in turn: fill phases run the table full
      for (int ph = 0; ph < 11; ph++) begin
         repeat (150) begin
            random_item(ph % 3, op, s, h);
            issue(op, s, h);
         end
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (tracker.awaited_replies.size() != 0) @(posedge clock);
      // wait on so a stray beat would still be caught
      repeat (20) @(posedge clock);
      if (tracker.errors == 0)
         $display("process_slot_allocator_unit: match");
      else
         $display("process_slot_allocator_unit: mismatch");
      $finish;
   end

   // receiver: stretches of differing ready patterns, plus one long hold-off
   initial begin : rsp_side
      int mode;
      int len;
      bit held;
      rsp_tready <= 1'b0;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         // long hold-off once mid run: the block fills and stalls its input
         if (!held && tracker.checked > 500) begin
            held = 1'b1;
            repeat (400) begin
               rsp_tready <= 1'b0;
               @(posedge clock);
            end
         end
         mode = $urandom_range(0, 3);
         len  = $urandom_range(16, 96);
         for (int k = 0; k < len; k++) begin
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 3) != 0);
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= (k % 4 == 3);
            endcase
            @(posedge clock);
         end
      end
   end

   // hard stop if the handshakes hang
   initial begin : watchdog
      #RUN_LIMIT;
      $display("process_slot_allocator_unit: mismatch");
      $finish;
   end

endmodule
